/* src/bbs_pkg.sv */
// Shared types and constants for the bucketed bitmap set.
package bbs_pkg;

    localparam int ELEM_W      = 16;
    localparam int BIT_W       = 6;
    localparam int WORD_BITS   = 64;
    localparam int WIDX_W      = ELEM_W - BIT_W;
    localparam int USED_W      = WIDX_W + 1;
    localparam int IDX_RANGE   = 1 << WIDX_W;
    localparam int BKT_W       = 10;
    localparam int CFG_W       = 4;
    localparam int MAX_BUCKET_BITS = 10;
    localparam int BUCKET_BITS_RESET = 10;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FIND   = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS,
        ST_QRY
    } state_t;

endpackage

/* src/bucketed_bitmap_set.sv */
// Top level of the bucketed bitmap set: control, configuration and result registers.
//
// The set lives in one memory of 64-bit words (element e sits in word e>>6 at bit e&63).
// After reset the block first clears the memory, one word per cycle; busy stays high
// during that pass and configuration writes are still taken. A request is accepted when
// start is high and busy is low. For an insert the accept cycle reads the word and the
// next cycle writes it back with the new bit set; busy stays high during the write-back,
// so a new request waits for it. A find-next request ends in its accept cycle when the
// first word of its bucket at or after the start word lies at or past the words in use;
// otherwise the walk reads one word of the bucket per cycle through the single read port,
// stepping by 2^bucket_bits words, and stops at the first hit or at the end of the words
// in use. The result of every request appears on the result ports for exactly one cycle
// with done high, in the cycle after the request's last cycle; the receiver cannot stall
// it, and a new request may be accepted in that same cycle. The bucket_bits register is
// written through cfg_valid/cfg_data (cfg_ready is always high) and should only be
// changed while no request is in flight; values above 10 act as 10.
module bucketed_bitmap_set #(
    parameter int WORDS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          command,
    input  logic [bbs_pkg::ELEM_W-1:0]    element,
    input  logic [bbs_pkg::BKT_W-1:0]     bucket,
    input  logic [bbs_pkg::ELEM_W-1:0]    start_element,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbs_pkg::CFG_W-1:0]     cfg_data,
    output logic                          done,
    output logic [bbs_pkg::BKT_W-1:0]     inserted_bucket,
    output logic                          found,
    output logic [bbs_pkg::ELEM_W-1:0]    member
);
    import bbs_pkg::*;

    // Words above the 16-bit element range can never be addressed.
    localparam int DEPTH = (WORDS < IDX_RANGE) ? WORDS : IDX_RANGE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [CFG_W-1:0]       bits_reg;
    logic [USED_W-1:0]      used_words_reg, used_words_next;
    logic [USED_W-1:0]      w_reg, w_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic                   in_range_reg, in_range_next;
    logic                   done_reg, done_next;
    logic [BKT_W-1:0]       ibucket_reg, ibucket_next;
    logic                   found_reg, found_next;
    logic [ELEM_W-1:0]      member_reg, member_next;

    logic [CFG_W-1:0]       eff_bits;
    logic [USED_W-1:0]      stride;
    logic [BKT_W-1:0]       bmask;
    logic                   accept;
    logic                   is_find;

    logic [WIDX_W-1:0]      e_word;
    logic                   ins_ok;
    logic [WIDX_W-1:0]      sw;
    logic [BKT_W-1:0]       b_masked;
    logic [BKT_W-1:0]       gap;
    logic [USED_W-1:0]      w0;
    logic [BIT_W-1:0]       bit0;
    logic                   q_ok0;
    logic [USED_W-1:0]      w_step;
    logic                   step_ok;
    logic [USED_W-1:0]      w_plus1;

    logic                   scan_hit;
    logic [BIT_W-1:0]       scan_pos;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    word_t                  wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    word_t                  rd_data;

    bbs_word_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbs_first_set u_first (
        .word      (rd_data),
        .start_bit (bit_reg),
        .hit       (scan_hit),
        .pos       (scan_pos)
    );

    // The bucket count saturates at 2^10; the stride is one bucket count of words.
    assign eff_bits = (bits_reg > CFG_W'(MAX_BUCKET_BITS)) ? CFG_W'(MAX_BUCKET_BITS)
                                                           : bits_reg;
    assign stride   = USED_W'(1) << eff_bits;
    assign bmask    = BKT_W'(stride - USED_W'(1));

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign is_find   = (command == CMD_FIND);
    assign cfg_ready = 1'b1;

    // Insert address and range check.
    assign e_word = element[ELEM_W-1:BIT_W];
    assign ins_ok = ({1'b0, e_word} < USED_W'(DEPTH));

    // First word of the bucket at or after the start word. Only when that word is the
    // start word itself are the bits below the start bit skipped.
    assign sw       = start_element[ELEM_W-1:BIT_W];
    assign b_masked = bucket & bmask;
    assign gap      = (b_masked - sw) & bmask;
    assign w0       = (sw <= b_masked) ? {1'b0, b_masked} : ({1'b0, sw} + {1'b0, gap});
    assign bit0     = (w0 == {1'b0, sw}) ? start_element[BIT_W-1:0] : '0;
    assign q_ok0    = (w0 < used_words_reg);

    // Next word of the walk; words at or past the used count read as empty.
    assign w_step  = w_reg + stride;
    assign step_ok = (w_step < used_words_reg);
    assign w_plus1 = w_reg + USED_W'(1);

    // Memory port control.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_find)
                    begin
                        rd_en   = q_ok0;
                        rd_addr = w0[AW-1:0];
                    end
                    else
                    begin
                        rd_en   = ins_ok;
                        rd_addr = e_word[AW-1:0];
                    end
                end
            end
            ST_QRY:
            begin
                rd_en   = !scan_hit && step_ok;
                rd_addr = w_step[AW-1:0];
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
            end
            ST_INS:
            begin
                wr_en   = in_range_reg;
                wr_addr = w_reg[AW-1:0];
                wr_data = rd_data | (word_t'(1) << bit_reg);
            end
            default:
            begin
                wr_en   = 1'b0;
                wr_addr = '0;
                wr_data = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!is_find)
                    begin
                        state_next = ST_INS;
                    end
                    else if (q_ok0)
                    begin
                        state_next = ST_QRY;
                    end
                end
            end
            ST_INS:
            begin
                state_next = ST_IDLE;
            end
            ST_QRY:
            begin
                if (scan_hit || !step_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result registers.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        used_words_next = used_words_reg;
        w_next          = w_reg;
        bit_next        = bit_reg;
        in_range_next   = in_range_reg;
        done_next       = 1'b0;
        ibucket_next    = ibucket_reg;
        found_next      = found_reg;
        member_next     = member_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_find)
                    begin
                        w_next   = w0;
                        bit_next = bit0;
                        if (!q_ok0)
                        begin
                            done_next    = 1'b1;
                            ibucket_next = '0;
                            found_next   = 1'b0;
                            member_next  = '0;
                        end
                    end
                    else
                    begin
                        w_next        = {1'b0, e_word};
                        bit_next      = element[BIT_W-1:0];
                        in_range_next = ins_ok;
                    end
                end
            end
            ST_INS:
            begin
                done_next    = 1'b1;
                ibucket_next = w_reg[BKT_W-1:0] & bmask;
                found_next   = 1'b0;
                member_next  = '0;
                if (in_range_reg && (w_plus1 > used_words_reg))
                begin
                    used_words_next = w_plus1;
                end
            end
            ST_QRY:
            begin
                if (scan_hit)
                begin
                    done_next    = 1'b1;
                    ibucket_next = '0;
                    found_next   = 1'b1;
                    member_next  = {w_reg[WIDX_W-1:0], scan_pos};
                end
                else if (step_ok)
                begin
                    w_next   = w_step;
                    bit_next = '0;
                end
                else
                begin
                    done_next    = 1'b1;
                    ibucket_next = '0;
                    found_next   = 1'b0;
                    member_next  = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            used_words_reg <= '0;
            done_reg       <= 1'b0;
            bits_reg       <= CFG_W'(BUCKET_BITS_RESET);
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            used_words_reg <= used_words_next;
            done_reg       <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                bits_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg        <= w_next;
        bit_reg      <= bit_next;
        in_range_reg <= in_range_next;
        ibucket_reg  <= ibucket_next;
        found_reg    <= found_next;
        member_reg   <= member_next;
    end

    assign done            = done_reg;
    assign inserted_bucket = ibucket_reg;
    assign found           = found_reg;
    assign member          = member_reg;

    // An insert's write-back cycle always produces a result on the next cycle.
    a_ins_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |=> done_reg)
        else $error("insert finished without a result");

    // The count of words in use never shrinks.
    a_used_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (used_words_reg >= $past(used_words_reg)))
        else $error("used word count decreased");

    // A found member always lies in a word that is in use.
    a_found_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && found_reg) |->
            ({1'b0, member_reg[ELEM_W-1:BIT_W]} < used_words_reg))
        else $error("found member outside the words in use");

    // The walk only visits words that are in use.
    a_walk_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QRY) |-> (w_reg < used_words_reg))
        else $error("walk visited a word past the words in use");

endmodule

/* src/bbs_word_ram.sv */
// Single-port-write, single-port-read word memory with a registered read.
module bbs_word_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  bbs_pkg::word_t       wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output bbs_pkg::word_t       rd_data
);
    import bbs_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/bbs_first_set.sv */
// Finds the lowest set bit of a word at or above a start bit.
module bbs_first_set (
    input  bbs_pkg::word_t                 word,
    input  logic [bbs_pkg::BIT_W-1:0]      start_bit,
    output logic                           hit,
    output logic [bbs_pkg::BIT_W-1:0]      pos
);
    import bbs_pkg::*;

    word_t masked;

    assign masked = word & ({WORD_BITS{1'b1}} << start_bit);
    assign hit    = |masked;

    // Scan from the top down so that the lowest set bit wins.
    always_comb
    begin
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                pos = BIT_W'(i);
            end
        end
    end

endmodule
